>>> rtl/sha1_pkg.sv
// SHA-1 hasher package: initial hash values, round constants and the
// command and status structs between controller and datapath.
// No dependencies.
package sha1_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	// source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	// round function group: rounds 0-19, 20-39, 40-59, 60-79
	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} round_phase_t;

	typedef struct packed {
		logic         put;
		byte_src_t    src;
		logic         restart;
		logic         count;
		logic         load;
		logic         round;
		round_phase_t phase;
		logic         final_add;
		logic         emit;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_ge56;
		logic out_busy;
	} dp_sts_t;

endpackage

>>> rtl/sha1_dp.sv
// SHA-1 datapath: 512-bit block buffer that doubles as the message schedule
// window, round registers, chaining words, bit count and output register.
// Depends on sha1_pkg.
module sha1_dp import sha1_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  dp_cmd_t        cmd,
	output dp_sts_t        sts,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [159:0]   m_tdata
);

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [31:0]  chain_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] out_q;
	logic         out_valid_q;

	logic [63:0]  len_shift;
	logic [7:0]   in_byte;
	logic [31:0]  w0, w2, w8, w13, w_new;
	logic [31:0]  f_val, k_val, t_val;

	// pick the byte to append
	assign len_shift = bits_q << {fill_q[2:0], 3'b000};
	always_comb begin
		case (cmd.src)
			SRC_DATA: in_byte = data_byte;
			SRC_PAD:  in_byte = PAD_BYTE;
			SRC_ZERO: in_byte = 8'h00;
			SRC_LEN:  in_byte = len_shift[63:56];
			default:  in_byte = 8'h00;
		endcase
	end

	// schedule taps: word i of the window sits at the top minus 32*i
	assign w0    = blk_q[511:480];
	assign w2    = blk_q[447:416];
	assign w8    = blk_q[255:224];
	assign w13   = blk_q[95:64];
	assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
		w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

	// round function and constant
	always_comb begin
		case (cmd.phase)
			PH_CH: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = K0;
			end
			PH_PAR1: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K1;
			end
			PH_MAJ: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K2;
			end
			PH_PAR2: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K3;
			end
			default: begin
				f_val = 32'h0;
				k_val = 32'h0;
			end
		endcase
	end
	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w0;

	// shift bytes in, or advance the schedule window one word per round
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			blk_q <= {blk_q[503:0], in_byte};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// fill count, bit count and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			bits_q     <= '0;
			chain_q[0] <= H0;
			chain_q[1] <= H1;
			chain_q[2] <= H2;
			chain_q[3] <= H3;
			chain_q[4] <= H4;
		end else begin
			if (cmd.put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count) begin
				bits_q <= cmd.restart ? 64'd8 : bits_q + 64'd8;
			end
			if (cmd.restart) begin
				chain_q[0] <= H0;
				chain_q[1] <= H1;
				chain_q[2] <= H2;
				chain_q[3] <= H3;
				chain_q[4] <= H4;
			end else if (cmd.final_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

	// output register: load on emit, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= {chain_q[4], chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_q;
	assign sts.fill_last = (fill_q == 6'd63);
	assign sts.fill_ge56 = (fill_q[5:3] == 3'b111);
	assign sts.out_busy  = out_valid_q && !m_tready;

endmodule

>>> rtl/sha1_ctrl.sv
// SHA-1 controller: accepts input transfers, sequences padding, the 80
// rounds of each block, the chaining update and digest emission.
// Depends on sha1_pkg.
module sha1_ctrl import sha1_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    kind,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [6:0] rnd_q;
	logic       fin_q;
	logic       two_blk_q;
	logic       done_q;
	logic       acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// decode datapath commands
	always_comb begin
		cmd = '0;
		cmd.src = SRC_DATA;
		if (rnd_q < 7'd20) begin
			cmd.phase = PH_CH;
		end else if (rnd_q < 7'd40) begin
			cmd.phase = PH_PAR1;
		end else if (rnd_q < 7'd60) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end
		case (state_q)
			ST_IDLE: begin
				if (acc && !kind) begin
					cmd.put     = 1'b1;
					cmd.count   = 1'b1;
					cmd.restart = done_q;
				end else if (acc && !done_q) begin
					cmd.put = 1'b1;
					cmd.src = SRC_PAD;
				end
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				cmd.src = (sts.fill_ge56 && !two_blk_q) ? SRC_LEN : SRC_ZERO;
			end
			ST_ROUND: cmd.round     = 1'b1;
			ST_FINAL: cmd.final_add = 1'b1;
			ST_EMIT:  cmd.emit      = !sts.out_busy;
			default: ;
		endcase
		// a put that completes the block loads the working variables
		cmd.load = cmd.put && !cmd.restart && sts.fill_last;
	end

	// hold state, round count and message flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= '0;
			fin_q     <= 1'b0;
			two_blk_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && !kind) begin
						done_q <= 1'b0;
						if (!done_q && sts.fill_last) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end else if (acc && done_q) begin
						state_q <= ST_EMIT;
					end else if (acc) begin
						fin_q     <= 1'b1;
						two_blk_q <= sts.fill_ge56;
						rnd_q     <= '0;
						state_q   <= sts.fill_last ? ST_ROUND : ST_PAD;
					end
				end
				ST_PAD: begin
					if (sts.fill_last) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (two_blk_q) begin
						two_blk_q <= 1'b0;
						state_q   <= ST_PAD;
					end else begin
						fin_q   <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("digest emitted while output register still holds a result");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q <= LAST_ROUND)
		else $error("round counter out of range");

	a_done_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> state_q == ST_EMIT)
		else $error("digest completed without moving to emit");

	a_load_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_ROUND && rnd_q == 7'd0)
		else $error("full block did not start compression at round zero");

endmodule

>>> rtl/sha1_message_hasher.sv
// SHA-1 message hasher: streams message bytes in one transfer per byte and
// returns the 160-bit digest on a finish transfer. A byte transfer is taken
// whenever the controller is idle; the byte that completes a 64-byte block
// then holds the input off for the compression loop of 80 rounds, one round
// per cycle, and the chaining add. A finish inserts padding one byte per
// cycle up to the end of the block, the finish transfer's own pad byte
// included, compresses one or two blocks (the second after a full block of
// padding) and then loads the digest into the output register, once that
// register is free; a repeated finish loads the cached digest again, once
// the output register is free.
// A byte after a finish starts a new message. The digest is held in an
// output register, so bytes of the next message are taken while it waits.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.
module sha1_message_hasher import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic [0:0]   s_tuser,   // [0] kind: 0 message byte, 1 finish
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata    // digest_word0 .. digest_word4, 32 bits each
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence transfers, padding and rounds
	sha1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold block, schedule, chaining words and digest register
	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

>>> verif/sha1_message_hasher_tb.sv
// Self-checking testbench for sha1_message_hasher: streams message bytes and finish
// transfers, predicts each digest with a local SHA-1 model and checks the digest stream.
// Depends on sha1_pkg and the sha1_message_hasher RTL.
module sha1_message_hasher_tb import sha1_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum bit {
		KIND_BYTE,
		KIND_FINISH
	} item_kind_t;

	localparam int CYCLE_LIMIT = 1000000;
	// worst case after the last transfer: two padded blocks plus the output stage
	localparam int TAIL_CYCLES = 300;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic [0:0]   s_tuser;   // [0] kind: 0 message byte, 1 finish
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;   // digest_word0 .. digest_word4, 32 bits each

	// local SHA-1 state
	logic [31:0]  chain_h [5];
	logic [63:0]  msg_bits;
	logic [7:0]   blk_buf [64];
	logic [6:0]   blk_fill;
	bit           digest_done;

	logic [159:0] digest_q [$];
	int           err_count = 0;
	int           items_sent = 0;
	int           cycle_count = 0;
	bit           src_gaps = 1'b1;
	bit           sink_stalls = 1'b1;

	sha1_message_hasher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sha1_message_hasher test failed");
			$finish;
		end
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void hasher_clear();
		chain_h = '{H0, H1, H2, H3, H4};
		msg_bits = '0;
		foreach (blk_buf[i]) blk_buf[i] = 8'h00;
		blk_fill = '0;
		digest_done = 1'b0;
	endfunction

	// run 80 rounds over the buffered block and fold into the chaining words
	function automatic void hash_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			case (round_phase_t'(2'(r / 20)))
				PH_CH: begin
					f = (b & c) | (~b & d);
					k = K0;
				end
				PH_PAR1: begin
					f = b ^ c ^ d;
					k = K1;
				end
				PH_MAJ: begin
					f = (b & c) | (b & d) | (c & d);
					k = K2;
				end
				default: begin
					f = b ^ c ^ d;
					k = K3;
				end
			endcase
			t = rol32(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
	endfunction

	function automatic void buf_put(input logic [7:0] v);
		blk_buf[blk_fill[5:0]] = v;
		blk_fill = blk_fill + 7'd1;
	endfunction

	// advance the local hasher by one accepted transfer
	function automatic void predict_digest(input item_kind_t kind, input logic [7:0] data);
		if (kind == KIND_BYTE) begin
			if (digest_done)
				hasher_clear();
			buf_put(data);
			msg_bits += 64'd8;
			if (blk_fill >= 7'd64) begin
				hash_block();
				blk_fill = '0;
			end
			return;
		end
		if (!digest_done) begin
			buf_put(PAD_BYTE);
			if (blk_fill > 7'd56) begin
				while (blk_fill < 7'd64)
					buf_put(8'h00);
				hash_block();
				blk_fill = '0;
			end
			while (blk_fill < 7'd56)
				buf_put(8'h00);
			for (int i = 0; i < 8; i++)
				buf_put(msg_bits[56 - 8*i +: 8]);
			hash_block();
			blk_fill = '0;
			digest_done = 1'b1;
		end
		digest_q.push_back({chain_h[4], chain_h[3], chain_h[2], chain_h[1], chain_h[0]});
	endfunction

	// sink side: random stall bursts while enabled
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// compare each digest transfer with the oldest prediction
	always @(posedge clk) begin
		logic [159:0] want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (digest_q.size() == 0) begin
				$error("digest transfer with no digest pending: %h", m_tdata);
				err_count++;
			end else begin
				want = digest_q.pop_front();
				for (int i = 0; i < 5; i++) begin
					if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
						$error("digest_word%0d mismatch: expected %h, got %h",
							i, want[32*i +: 32], m_tdata[32*i +: 32]);
						err_count++;
					end
				end
			end
		end
	end

	// drive one transfer, hold until accepted, then update the prediction
	task automatic send_item(input item_kind_t kind, input logic [7:0] data);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_digest(kind, data);
		items_sent++;
	endtask

	task automatic send_finish();
		send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_message(input int len);
		repeat (len) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
		send_finish();
	endtask

	// release the input, wait for all digests, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_message();
		send_item(KIND_FINISH, 8'hFF);
		send_item(KIND_FINISH, 8'h00);
		drain();
	endtask

	task automatic test_byte_extremes();
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h5A);
		send_item(KIND_BYTE, 8'hA5);
		send_item(KIND_FINISH, 8'hFF);
		drain();
	endtask

	task automatic test_restart_after_finish();
		send_item(KIND_BYTE, 8'h01);
		send_item(KIND_FINISH, 8'h80);
		send_item(KIND_BYTE, 8'hFE);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_FINISH, 8'h7F);
		send_item(KIND_FINISH, 8'h01);
		send_item(KIND_BYTE, 8'h61);
		send_item(KIND_FINISH, 8'h00);
		drain();
	endtask

	// lengths around the point where padding spills into a second block
	task automatic test_pad_boundaries();
		int lens [5] = '{55, 56, 57, 63, 64};
		foreach (lens[i]) send_message(lens[i]);
		drain();
	endtask

	task automatic test_random_messages();
		while (items_sent < 640) begin
			if ($urandom_range(0, 3) != 0)
				send_message($urandom_range(0, 24));
			else
				send_message($urandom_range(25, 130));
			if ($urandom_range(0, 5) == 0)
				send_finish();
		end
		drain();
	endtask

	// unstructured mix of bytes and finishes
	task automatic test_noise();
		repeat (60) begin
			if ($urandom_range(0, 2) == 0)
				send_finish();
			else
				send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
		end
		send_finish();
		drain();
	endtask

	// back-to-back transfers with no gaps or stalls
	task automatic test_steady_stream();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		while (items_sent < 800)
			send_message($urandom_range(0, 70));
		drain();
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= KIND_BYTE;
		s_tdata  <= 8'h00;
		hasher_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_byte_extremes();
		test_restart_after_finish();
		test_pad_boundaries();
		test_random_messages();
		test_noise();
		test_steady_stream();

		if (digest_q.size() != 0) begin
			$error("%0d digests never arrived", digest_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("sha1_message_hasher test passed");
		else
			$display("sha1_message_hasher test failed");
		$finish;
	end

endmodule
